// ----- hdl/bmp_blit_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP blitter package
// Shared constants, header offsets and result status codes for the 24-bit
// BMP to frame-buffer blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmp_blit_pkg;

	// Frame and image limits (defaults for the top-level parameters)
	localparam int FB_WIDTH_DEF      = 640;
	localparam int FB_HEIGHT_DEF     = 480;
	localparam int MAX_IMAGE_DIM_DEF = 1024;

	// Fixed field widths
	localparam int DATA_W       = 8;
	localparam int ADDR_W       = 19;
	localparam int PIXEL_W      = 24;
	localparam int ORIGIN_ROW_W = 9;
	localparam int ORIGIN_COL_W = 10;
	localparam int CFG_DATA_W   = 10;
	localparam int HDR_CNT_W    = 6;
	localparam int HDR_WORD_W   = 32;

	// Byte offsets within the file
	localparam int INFO_HEADER_AT = 14;
	localparam int WIDTH_AT       = INFO_HEADER_AT + 4;
	localparam int HEIGHT_AT      = INFO_HEADER_AT + 8;
	localparam int PIXELS_AT      = 54;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_ORIGIN_ROW = 1'b0,
		CFG_ORIGIN_COL = 1'b1
	} cfg_index_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_WRITTEN = 2'd0,
		ST_DROPPED = 2'd1,
		ST_HDR_ERR = 2'd2
	} status_t;

	// Byte position within a B,G,R triple
	typedef enum logic [1:0] {
		PH_BLUE  = 2'd0,
		PH_GREEN = 2'd1,
		PH_RED   = 2'd2
	} phase_t;

endpackage

`default_nettype wire

// ----- hdl/bmp_blit_if.sv -----
// ----------------------------------------------------------------------------
// BMP blitter channels
// Valid/ready channels for file bytes in and frame-buffer writes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// File byte stream
interface bmp_blit_byte_if;
	logic                            valid;
	logic                            ready;
	logic [bmp_blit_pkg::DATA_W-1:0] data_byte;
	logic                            first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// Frame-buffer write stream
interface bmp_blit_pix_if;
	logic                             valid;
	logic                             ready;
	logic [bmp_blit_pkg::ADDR_W-1:0]  fb_address;
	logic [bmp_blit_pkg::PIXEL_W-1:0] pixel_value;
	bmp_blit_pkg::status_t            status;
	logic                             last_pixel;

	modport source (output valid, output fb_address, output pixel_value, output status,
		output last_pixel, input ready);
	modport sink   (input valid, input fb_address, input pixel_value, input status,
		input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- hdl/bmp24_to_framebuffer_blit.sv -----
// ----------------------------------------------------------------------------
// 24-bit BMP to frame-buffer blitter
// Parses a bottom-up 24-bit BMP byte stream and emits one frame-buffer write
// per pixel, flipped upright and offset by the image origin.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    word
//  src       in   valid/ready  data_byte, first_byte
//  dst       out  valid/ready  fb_address, pixel_value, status, last_pixel
//  cfg       in   cfg_we       cfg_index, cfg_wdata (origin row, origin column)
//
//  One byte is taken every cycle while src.ready is high; the byte that
//  completes a pixel passes the parse stage, then the address multiply stage.
//  A pixel needs three bytes, so at most one word per three bytes appears.
//  arst_n clears the parser, the configuration registers and both stage
//  valid flags.
//  A stall on dst holds a full stage 2; src.ready drops only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmp24_to_framebuffer_blit #(
	parameter int FB_WIDTH      = bmp_blit_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT     = bmp_blit_pkg::FB_HEIGHT_DEF,
	parameter int MAX_IMAGE_DIM = bmp_blit_pkg::MAX_IMAGE_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire bmp_blit_pkg::cfg_index_t            cfg_index,
	input  wire logic [bmp_blit_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bmp_blit_byte_if.sink                            src,
	bmp_blit_pix_if.source                           dst
);

	localparam int DIM_W  = $clog2(MAX_IMAGE_DIM + 1);
	localparam int ROW_W  = ((DIM_W > bmp_blit_pkg::ORIGIN_ROW_W) ? DIM_W
		: bmp_blit_pkg::ORIGIN_ROW_W) + 1;
	localparam int COL_W  = ((DIM_W > bmp_blit_pkg::ORIGIN_COL_W) ? DIM_W
		: bmp_blit_pkg::ORIGIN_COL_W) + 1;
	localparam int FBW_W  = $clog2(FB_WIDTH + 1);
	localparam int PROD_W = ROW_W + FBW_W + 1;
	localparam int AW     = bmp_blit_pkg::ADDR_W;
	localparam int HW     = bmp_blit_pkg::HDR_WORD_W;
	localparam int HCW    = bmp_blit_pkg::HDR_CNT_W;
	localparam int RW     = bmp_blit_pkg::ORIGIN_ROW_W;
	localparam int CW     = bmp_blit_pkg::ORIGIN_COL_W;
	localparam int DW     = bmp_blit_pkg::DATA_W;

	// Configuration registers
	logic [RW-1:0] origin_row_q;
	logic [CW-1:0] origin_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_row_q <= '0;
			origin_col_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmp_blit_pkg::CFG_ORIGIN_ROW: origin_row_q <= cfg_wdata[RW-1:0];
				bmp_blit_pkg::CFG_ORIGIN_COL: origin_col_q <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// Parser state
	logic [HCW-1:0]       header_count_q;
	logic [HW-1:0]        header_word_q;
	logic [DIM_W-1:0]     image_width_q;
	logic [DIM_W-1:0]     image_height_q;
	logic [DIM_W-1:0]     column_count_q;
	logic [DIM_W-1:0]     source_row_q;
	bmp_blit_pkg::phase_t byte_phase_q;
	logic [1:0]           pad_left_q;
	logic [DW-1:0]        blue_hold_q;
	logic [DW-1:0]        green_hold_q;
	logic                 parse_failed_q;

	// Next-state values
	logic [HCW-1:0]       hc_d;
	logic [HW-1:0]        hw_d;
	logic [DIM_W-1:0]     iw_d;
	logic [DIM_W-1:0]     ih_d;
	logic [DIM_W-1:0]     cc_d;
	logic [DIM_W-1:0]     sr_d;
	bmp_blit_pkg::phase_t ph_d;
	logic [1:0]           pad_d;
	logic [DW-1:0]        bh_d;
	logic [DW-1:0]        gh_d;
	logic                 pf_d;

	// Result of the current byte
	logic                 res_v;
	logic                 res_err;
	logic                 res_last;
	logic [ROW_W-1:0]     res_row;
	logic [COL_W-1:0]     res_col;

	// Stage 1 and output registers
	logic                         valid_s1;
	logic                         err_s1;
	logic                         last_s1;
	logic                         inframe_s1;
	logic [ROW_W-1:0]             row_s1;
	logic [COL_W-1:0]             col_s1;
	logic [bmp_blit_pkg::PIXEL_W-1:0] pixel_s1;

	logic                             out_valid_q;
	logic [AW-1:0]                    fb_address_q;
	logic [bmp_blit_pkg::PIXEL_W-1:0] pixel_value_q;
	bmp_blit_pkg::status_t            status_q;
	logic                             last_pixel_q;

	logic adv_s2;
	logic accept;

	assign adv_s2    = !out_valid_q || dst.ready;
	assign src.ready = !valid_s1 || adv_s2;
	assign accept    = src.valid && src.ready;

	// Parse one byte: header capture, padding skip, triple assembly
	always_comb begin
		logic [HW-1:0] hw_new;
		hc_d     = src.first_byte ? '0 : header_count_q;
		hw_d     = src.first_byte ? '0 : header_word_q;
		iw_d     = src.first_byte ? '0 : image_width_q;
		ih_d     = src.first_byte ? '0 : image_height_q;
		cc_d     = src.first_byte ? '0 : column_count_q;
		sr_d     = src.first_byte ? '0 : source_row_q;
		ph_d     = src.first_byte ? bmp_blit_pkg::PH_BLUE : byte_phase_q;
		pad_d    = src.first_byte ? '0 : pad_left_q;
		bh_d     = src.first_byte ? '0 : blue_hold_q;
		gh_d     = src.first_byte ? '0 : green_hold_q;
		pf_d     = src.first_byte ? 1'b0 : parse_failed_q;
		res_v    = 1'b0;
		res_err  = 1'b0;
		res_last = 1'b0;
		res_row  = '0;
		res_col  = '0;
		hw_new   = {src.data_byte, hw_d[HW-1:DW]};

		if (32'(hc_d) < 32'(bmp_blit_pkg::PIXELS_AT)) begin
			// header byte
			if (32'(hc_d) >= 32'(bmp_blit_pkg::WIDTH_AT) &&
				32'(hc_d) < 32'(bmp_blit_pkg::HEIGHT_AT + 4)) begin
				hw_d = hw_new;
			end
			if (32'(hc_d) == 32'(bmp_blit_pkg::WIDTH_AT + 3)) begin
				if (hw_d == '0 || 64'(hw_d) > 64'(MAX_IMAGE_DIM)) pf_d = 1'b1;
				else iw_d = hw_d[DIM_W-1:0];
			end else if (32'(hc_d) == 32'(bmp_blit_pkg::HEIGHT_AT + 3)) begin
				if (pf_d || hw_d == '0 || 64'(hw_d) > 64'(MAX_IMAGE_DIM)) begin
					pf_d    = 1'b1;
					res_v   = 1'b1;
					res_err = 1'b1;
				end else begin
					ih_d = hw_d[DIM_W-1:0];
				end
			end
			hc_d = hc_d + HCW'(1);
		end else if (!pf_d && sr_d < ih_d) begin
			if (pad_d != '0) begin
				// row padding
				pad_d = pad_d - 2'd1;
			end else begin
				case (ph_d)
					bmp_blit_pkg::PH_BLUE: begin
						bh_d = src.data_byte;
						ph_d = bmp_blit_pkg::PH_GREEN;
					end
					bmp_blit_pkg::PH_GREEN: begin
						gh_d = src.data_byte;
						ph_d = bmp_blit_pkg::PH_RED;
					end
					bmp_blit_pkg::PH_RED: begin
						// pixel complete: flip the row and place it
						ph_d    = bmp_blit_pkg::PH_BLUE;
						res_v   = 1'b1;
						res_row = ROW_W'(origin_row_q) + ROW_W'(ih_d - DIM_W'(1) - sr_d);
						res_col = COL_W'(origin_col_q) + COL_W'(cc_d);
						cc_d    = cc_d + DIM_W'(1);
						if (cc_d >= iw_d) begin
							cc_d     = '0;
							pad_d    = iw_d[1:0];
							sr_d     = sr_d + DIM_W'(1);
							res_last = (sr_d >= ih_d);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			header_word_q  <= '0;
			image_width_q  <= '0;
			image_height_q <= '0;
			column_count_q <= '0;
			source_row_q   <= '0;
			byte_phase_q   <= bmp_blit_pkg::PH_BLUE;
			pad_left_q     <= '0;
			blue_hold_q    <= '0;
			green_hold_q   <= '0;
			parse_failed_q <= 1'b0;
		end else if (accept) begin
			header_count_q <= hc_d;
			header_word_q  <= hw_d;
			image_width_q  <= iw_d;
			image_height_q <= ih_d;
			column_count_q <= cc_d;
			source_row_q   <= sr_d;
			byte_phase_q   <= ph_d;
			pad_left_q     <= pad_d;
			blue_hold_q    <= bh_d;
			green_hold_q   <= gh_d;
			parse_failed_q <= pf_d;
		end
	end

	// Stage 1: result of the parse, frame clipping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= accept && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_v) begin
			err_s1     <= res_err;
			last_s1    <= res_last;
			row_s1     <= res_row;
			col_s1     <= res_col;
			inframe_s1 <= (32'(res_row) < 32'(FB_HEIGHT)) && (32'(res_col) < 32'(FB_WIDTH));
			pixel_s1   <= res_err ? '0 : {bh_d, gh_d, src.data_byte};
		end
	end

	// Stage 2: frame-buffer address and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_value_q <= pixel_s1;
			last_pixel_q  <= last_s1;
			if (err_s1) begin
				fb_address_q <= '0;
				status_q     <= bmp_blit_pkg::ST_HDR_ERR;
			end else if (inframe_s1) begin
				fb_address_q <= AW'(PROD_W'(row_s1) * PROD_W'(FB_WIDTH) + PROD_W'(col_s1));
				status_q     <= bmp_blit_pkg::ST_WRITTEN;
			end else begin
				fb_address_q <= '0;
				status_q     <= bmp_blit_pkg::ST_DROPPED;
			end
		end
	end

	assign dst.valid       = out_valid_q;
	assign dst.fb_address  = fb_address_q;
	assign dst.pixel_value = pixel_value_q;
	assign dst.status      = status_q;
	assign dst.last_pixel  = last_pixel_q;

endmodule

`default_nettype wire

// ----- tb/bmp24_to_framebuffer_blit_test.sv -----
// ----------------------------------------------------------------------------
// BMP blitter testbench
// Streams whole 24-bit BMP files into the blitter one byte word at a time,
// predicts every frame-buffer word from a behavioural copy of the parser and
// compares the words leaving the block field by field. A table of hand-picked
// files comes first (start without a mark, corner placement, bad headers,
// the opening pixels of the widest and tallest images, restarts), then random
// files with random placement, random idling on the byte side and random
// stalls on the pixel side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp24_to_framebuffer_blit_test;

	localparam int unsigned RAND_BYTES     = 340;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	// One frame-buffer word as it leaves the block
	typedef struct packed {
		logic [bmp_blit_pkg::ADDR_W-1:0]  addr;
		logic [bmp_blit_pkg::PIXEL_W-1:0] pix;
		bmp_blit_pkg::status_t            st;
		logic                             last;
	} fb_word_t;

	// One file to stream: header words, placement, pixel fill, early restart
	typedef struct {
		bit           mark;     // first_byte on byte 0
		int unsigned  wid;      // header width word
		int unsigned  hgt;      // header height word
		bit           set_cfg;  // move the image origin before the file
		int unsigned  row0;
		int unsigned  col0;
		logic [23:0]  fill;     // B,G,R for every pixel unless random
		bit           rand_px;
		int           cut;      // stop after this many bytes, -1 for whole file
		bit           typed;    // last result of the file given below
		fb_word_t     want;
	} file_desc_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	bmp_blit_pkg::cfg_index_t            cfg_index;
	logic [bmp_blit_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bmp_blit_byte_if byte_ch ();
	bmp_blit_pix_if  pix_ch ();

	bmp24_to_framebuffer_blit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.src       (byte_ch),
		.dst       (pix_ch)
	);

	// Expected frame-buffer words, oldest first
	fb_word_t    pending_words [$];
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stream_bytes = 0;
	bit          calm          = 1'b0;
	bit          src_idle_mode = 1'b1;
	bit          dst_stall_mode = 1'b1;
	bit          cur_typed     = 1'b0;
	fb_word_t    cur_want      = '0;

	// Parser copy
	int unsigned          frame_row0, frame_col0;
	int unsigned          hdr_pos, img_w, img_h, col_pos, file_row, pad_cnt;
	logic [31:0]          hdr_shift;
	logic [7:0]           blue_b, green_b;
	bmp_blit_pkg::phase_t rgb_phase;
	bit                   hdr_bad;

	// Hand-picked files
	file_desc_t demo_files [17] = '{
		'{0, 1, 1, 1, 0, 0, 24'h000000, 0, -1, 1,
			'{19'd0, 24'h000000, bmp_blit_pkg::ST_WRITTEN, 1'b1}},
		'{1, 1, 1, 1, 479, 639, 24'hFFFFFF, 0, -1, 1,
			'{19'd307199, 24'hFFFFFF, bmp_blit_pkg::ST_WRITTEN, 1'b1}},
		'{1, 2, 2, 0, 0, 0, 24'h123456, 0, -1, 1,
			'{19'd0, 24'h123456, bmp_blit_pkg::ST_DROPPED, 1'b1}},
		'{1, 0, 4, 0, 0, 0, 24'h0, 0, 26, 1,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_HDR_ERR, 1'b0}},
		'{1, 3, 0, 0, 0, 0, 24'h0, 0, 26, 1,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_HDR_ERR, 1'b0}},
		'{1, 32'h8000_0000, 2, 0, 0, 0, 24'h0, 0, 26, 1,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_HDR_ERR, 1'b0}},
		'{1, 2, 32'hFFFF_FFFF, 0, 0, 0, 24'h0, 0, 26, 1,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_HDR_ERR, 1'b0}},
		'{1, 1025, 1, 0, 0, 0, 24'h0, 0, 26, 1,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_HDR_ERR, 1'b0}},
		'{1, 1, 1025, 0, 0, 0, 24'h0, 0, 26, 1,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_HDR_ERR, 1'b0}},
		'{1, 1024, 1, 1, 0, 0, 24'hAA55C3, 0, 66, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 1, 1024, 0, 0, 0, 24'h0FF081, 0, 66, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 3, 3, 1, 100, 200, 24'h0, 1, -1, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 2, 5, 1, 478, 5, 24'h0, 1, -1, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 4, 3, 0, 0, 0, 24'h0, 1, 80, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 5, 2, 0, 0, 0, 24'h0, 1, -1, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 4, 3, 0, 0, 0, 24'h0, 1, 30, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}},
		'{1, 6, 2, 0, 0, 0, 24'h0, 1, -1, 0,
			'{19'd0, 24'h0, bmp_blit_pkg::ST_WRITTEN, 1'b0}}
	};

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Back to byte 0 of a file
	function automatic void parse_restart();
		hdr_pos   = 0;
		hdr_shift = '0;
		img_w     = 0;
		img_h     = 0;
		col_pos   = 0;
		file_row  = 0;
		rgb_phase = bmp_blit_pkg::PH_BLUE;
		pad_cnt   = 0;
		blue_b    = '0;
		green_b   = '0;
		hdr_bad   = 1'b0;
	endfunction

	function automatic bit dim_bad(input logic [31:0] v);
		return (v == 0) || (v > bmp_blit_pkg::MAX_IMAGE_DIM_DEF);
	endfunction

	// Frame-buffer word caused by one file byte, if any
	function automatic bit blit_predict(input logic [7:0] d, input logic fb,
			output fb_word_t w);
		int unsigned idx, fr, fc;
		w = '0;
		if (fb)
			parse_restart();

		// header: only the two size words matter
		if (hdr_pos < bmp_blit_pkg::PIXELS_AT) begin
			idx = hdr_pos;
			hdr_pos++;
			if (idx >= bmp_blit_pkg::WIDTH_AT && idx < bmp_blit_pkg::HEIGHT_AT + 4)
				hdr_shift = {d, hdr_shift[31:8]};
			if (idx == bmp_blit_pkg::WIDTH_AT + 3) begin
				if (dim_bad(hdr_shift))
					hdr_bad = 1'b1;
				else
					img_w = hdr_shift;
			end else if (idx == bmp_blit_pkg::HEIGHT_AT + 3) begin
				if (hdr_bad || dim_bad(hdr_shift)) begin
					hdr_bad = 1'b1;
					w.st    = bmp_blit_pkg::ST_HDR_ERR;
					return 1'b1;
				end
				img_h = hdr_shift;
			end
			return 1'b0;
		end

		if (hdr_bad || file_row >= img_h)
			return 1'b0;
		if (pad_cnt != 0) begin
			pad_cnt--;
			return 1'b0;
		end

		case (rgb_phase)
			bmp_blit_pkg::PH_BLUE: begin
				blue_b    = d;
				rgb_phase = bmp_blit_pkg::PH_GREEN;
				return 1'b0;
			end
			bmp_blit_pkg::PH_GREEN: begin
				green_b   = d;
				rgb_phase = bmp_blit_pkg::PH_RED;
				return 1'b0;
			end
			default: ;
		endcase
		rgb_phase = bmp_blit_pkg::PH_BLUE;

		// stored bottom-up, so file row k lands on frame row start+h-1-k
		fr = frame_row0 + (img_h - 1 - file_row);
		fc = frame_col0 + col_pos;
		col_pos++;
		if (col_pos >= img_w) begin
			col_pos = 0;
			pad_cnt = img_w & 3;
			file_row++;
			w.last  = (file_row >= img_h);
		end
		w.pix = {blue_b, green_b, d};
		if (fr < bmp_blit_pkg::FB_HEIGHT_DEF && fc < bmp_blit_pkg::FB_WIDTH_DEF) begin
			w.addr = bmp_blit_pkg::ADDR_W'(fr * bmp_blit_pkg::FB_WIDTH_DEF + fc);
			w.st   = bmp_blit_pkg::ST_WRITTEN;
		end else begin
			w.st = bmp_blit_pkg::ST_DROPPED;
		end
		return 1'b1;
	endfunction

	// Check outgoing words, then predict from the byte taken; watchdog
	always @(posedge clk) begin : check_and_predict
		fb_word_t exp_w, nxt_w;
		bit       src_acc, dst_acc;
		if (arst_n) begin
			src_acc = byte_ch.valid && byte_ch.ready;
			dst_acc = pix_ch.valid && pix_ch.ready;

			if (dst_acc) begin
				if (pending_words.size() == 0) begin
					$error("unexpected word: fb_address %0d pixel_value %h status %0d",
						pix_ch.fb_address, pix_ch.pixel_value, pix_ch.status);
					fail_count++;
				end else begin
					exp_w = pending_words.pop_front();
					if (pix_ch.fb_address !== exp_w.addr) begin
						$error("fb_address: expected %0d, got %0d", exp_w.addr,
							pix_ch.fb_address);
						fail_count++;
					end
					if (pix_ch.pixel_value !== exp_w.pix) begin
						$error("pixel_value: expected %h, got %h", exp_w.pix,
							pix_ch.pixel_value);
						fail_count++;
					end
					if (pix_ch.status !== exp_w.st) begin
						$error("status: expected %0d, got %0d", exp_w.st, pix_ch.status);
						fail_count++;
					end
					if (pix_ch.last_pixel !== exp_w.last) begin
						$error("last_pixel: expected %0d, got %0d", exp_w.last,
							pix_ch.last_pixel);
						fail_count++;
					end
				end
			end

			if (src_acc) begin
				if (blit_predict(byte_ch.data_byte, byte_ch.first_byte, nxt_w) || cur_typed)
					pending_words.push_back(cur_typed ? cur_want : nxt_w);
			end

			if (src_acc || dst_acc)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Pixel side: stall bursts, with stretches of none
	initial begin
		pix_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				dst_stall_mode = !dst_stall_mode;
			if (!calm && dst_stall_mode && ($urandom_range(0, 3) == 0)) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			pix_ch.ready <= 1'b1;
		end
	end

	// Present one byte word at a falling edge; returns at the falling edge after it is taken
	task automatic drive_byte(input logic [7:0] d, input logic fb, input bit typed,
			input fb_word_t want);
		if ($urandom_range(0, 47) == 0)
			src_idle_mode = !src_idle_mode;
		if (!calm && src_idle_mode && ($urandom_range(0, 2) == 0)) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= d;
		byte_ch.first_byte <= fb;
		cur_typed = typed;
		cur_want  = want;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drain the block, then move the image origin
	task automatic settle_and_write(input int unsigned row, input int unsigned col);
		byte_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= bmp_blit_pkg::CFG_ORIGIN_ROW;
		cfg_wdata <= bmp_blit_pkg::CFG_DATA_W'(row);
		@(negedge clk);
		cfg_index <= bmp_blit_pkg::CFG_ORIGIN_COL;
		cfg_wdata <= bmp_blit_pkg::CFG_DATA_W'(col);
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_row0 = row;
		frame_col0 = col;
	endtask

	// Stream one file: header, padded rows, a few stray bytes after
	task automatic send_file(input file_desc_t f);
		int unsigned row_len, px_bytes, final_idx, total, off, pos;
		bit          bad;
		logic [7:0]  d;
		bad       = dim_bad(f.wid) || dim_bad(f.hgt);
		row_len   = bad ? 0 : 3 * f.wid + (f.wid & 3);
		px_bytes  = bad ? 0 : row_len * f.hgt;
		final_idx = bad ? bmp_blit_pkg::HEIGHT_AT + 3
			: bmp_blit_pkg::PIXELS_AT + px_bytes - row_len + 3 * f.wid - 1;
		total     = bmp_blit_pkg::PIXELS_AT + px_bytes + $urandom_range(0, 4);
		for (int unsigned i = 0; i < total; i++) begin
			if (f.cut >= 0 && i >= f.cut)
				break;
			d = 8'($urandom());
			if (i >= bmp_blit_pkg::WIDTH_AT && i < bmp_blit_pkg::WIDTH_AT + 4) begin
				d = 8'(f.wid >> (8 * (i - bmp_blit_pkg::WIDTH_AT)));
			end else if (i >= bmp_blit_pkg::HEIGHT_AT && i < bmp_blit_pkg::HEIGHT_AT + 4) begin
				d = 8'(f.hgt >> (8 * (i - bmp_blit_pkg::HEIGHT_AT)));
			end else if (i >= bmp_blit_pkg::PIXELS_AT && !f.rand_px) begin
				off = i - bmp_blit_pkg::PIXELS_AT;
				if (off < px_bytes) begin
					pos = off % row_len;
					if (pos < 3 * f.wid) begin
						case (pos % 3)
							0:       d = f.fill[23:16];
							1:       d = f.fill[15:8];
							default: d = f.fill[7:0];
						endcase
					end
				end
			end
			drive_byte(d, (i == 0) ? f.mark : 1'b0, f.typed && (i == final_idx), f.want);
			stream_bytes++;
		end
	endtask

	// Main sequence
	initial begin : run
		file_desc_t  f;
		int unsigned r, c, rand_start;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = bmp_blit_pkg::CFG_ORIGIN_ROW;
		cfg_wdata          = '0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.first_byte = 1'b0;
		frame_row0         = 0;
		frame_col0         = 0;
		parse_restart();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hand-picked files
		foreach (demo_files[n]) begin
			if (demo_files[n].set_cfg)
				settle_and_write(demo_files[n].row0, demo_files[n].col0);
			send_file(demo_files[n]);
		end

		// random files, mostly well formed
		rand_start = stream_bytes;
		while (stream_bytes - rand_start < RAND_BYTES) begin
			if (stream_bytes - rand_start > RAND_BYTES * 4 / 5)
				calm = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0:       r = 0;
					1:       r = bmp_blit_pkg::FB_HEIGHT_DEF - 1;
					2:       r = $urandom_range(bmp_blit_pkg::FB_HEIGHT_DEF - 8,
						bmp_blit_pkg::FB_HEIGHT_DEF - 1);
					default: r = $urandom_range(0, bmp_blit_pkg::FB_HEIGHT_DEF - 1);
				endcase
				case ($urandom_range(0, 3))
					0:       c = 0;
					1:       c = bmp_blit_pkg::FB_WIDTH_DEF - 1;
					2:       c = $urandom_range(bmp_blit_pkg::FB_WIDTH_DEF - 12,
						bmp_blit_pkg::FB_WIDTH_DEF - 1);
					default: c = $urandom_range(0, bmp_blit_pkg::FB_WIDTH_DEF - 1);
				endcase
				settle_and_write(r, c);
			end
			f.mark    = ($urandom_range(0, 19) != 0);
			f.set_cfg = 1'b0;
			f.row0    = 0;
			f.col0    = 0;
			f.fill    = '0;
			f.rand_px = 1'b1;
			f.typed   = 1'b0;
			f.want    = '0;
			f.wid     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			f.hgt     = $urandom_range(1, 6);
			// bad header now and then
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 4))
					0: f.wid = 0;
					1: f.hgt = 0;
					2: f.wid = $urandom_range(bmp_blit_pkg::MAX_IMAGE_DIM_DEF + 1, 4095);
					3: f.hgt = $urandom() | 32'h8000_0000;
					default: begin
						f.wid = $urandom();
						f.hgt = $urandom();
						if (!dim_bad(f.wid) && !dim_bad(f.hgt))
							f.hgt = 0;
					end
				endcase
			end
			// restart early, in the header or among the pixels
			f.cut = ($urandom_range(0, 7) == 0)
				? int'($urandom_range(1, bmp_blit_pkg::PIXELS_AT + 40)) : -1;
			send_file(f);
		end

		// drain
		byte_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/bmp_blit_pkg.sv
hdl/bmp_blit_if.sv
hdl/bmp24_to_framebuffer_blit.sv
tb/bmp24_to_framebuffer_blit_test.sv
